/* hdl/bfks_pkg.sv */
// shared types, constants and helpers of the bounded fifo with key search
`default_nettype none

package bfks_pkg;

    localparam int DEPTH    = 8;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int OP_W     = 2;
    localparam int CODE_W   = 32;
    localparam int TAG_W    = 64;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int CAP_W    = 4;
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(5);

    typedef enum logic [OP_W-1:0] {
        OP_ENQ    = 2'd0,
        OP_DEQ    = 2'd1,
        OP_SEARCH = 2'd2,
        OP_LIST   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        t_op                      op;
        logic                     walk;
        logic signed [CODE_W-1:0] code;
        logic [TAG_W-1:0]         tag;
    } t_cmd;

    typedef struct packed {
        t_status                  status;
        logic [POS_W-1:0]         position;
        logic signed [CODE_W-1:0] entry_code;
        logic [TAG_W-1:0]         entry_tag;
        logic                     last;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_st;

    // slot index of head plus offset, modulo the store depth
    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] head,
                                                   input logic [CNT_W-1:0] off);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(head) + (CNT_W+1)'(off);
        if (s >= (CNT_W+1)'(DEPTH)) begin
            s = s - (CNT_W+1)'(DEPTH);
        end
        return ADDR_W'(s);
    endfunction

    // capacity register clamped to the store depth
    function automatic logic [CNT_W-1:0] cap_of(input logic [CAP_W-1:0] limit);
        logic [CNT_W-1:0] c;
        if (int'(limit) > DEPTH) begin
            c = CNT_W'(DEPTH);
        end else begin
            c = CNT_W'(limit);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* hdl/bfks_item_if.sv */
// input word channel: operation, code and name tag
`default_nettype none

interface bfks_item_if;
    logic                                valid;
    logic                                ready;
    logic [bfks_pkg::OP_W-1:0]           op;
    logic signed [bfks_pkg::CODE_W-1:0]  code;
    logic [bfks_pkg::TAG_W-1:0]          name_tag;

    modport source (output valid, op, code, name_tag, input ready);
    modport sink   (input valid, op, code, name_tag, output ready);
endinterface

`default_nettype wire

/* hdl/bfks_result_if.sv */
// result word channel
`default_nettype none

interface bfks_result_if;
    logic                                valid;
    logic                                ready;
    logic [bfks_pkg::STATUS_W-1:0]       status;
    logic [bfks_pkg::POS_W-1:0]          position;
    logic signed [bfks_pkg::CODE_W-1:0]  entry_code;
    logic [bfks_pkg::TAG_W-1:0]          entry_tag;
    logic                                last;

    modport source (output valid, status, position, entry_code, entry_tag, last,
                    input ready);
    modport sink   (input valid, status, position, entry_code, entry_tag, last,
                    output ready);
endinterface

`default_nettype wire

/* hdl/bfks_cfg_if.sv */
// capacity register write channel
`default_nettype none

interface bfks_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [bfks_pkg::CAP_W-1:0]    capacity_limit;

    modport source (output valid, capacity_limit, input ready);
    modport sink   (input valid, capacity_limit, output ready);
endinterface

`default_nettype wire

/* hdl/bfks_front.sv */
// front stage: accepts input words and decodes them into commands
`default_nettype none

module bfks_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    bfks_item_if.sink           i_item,
    input  bfks_pkg::t_q_st     i_q_st,
    output logic                o_push,
    output bfks_pkg::t_cmd      o_cmd
);

    logic             r_valid;
    bfks_pkg::t_cmd   r_cmd;
    bfks_pkg::t_cmd   n_cmd;
    logic             load;

    assign o_push       = r_valid && !i_q_st.full;
    assign i_item.ready = !r_valid || !i_q_st.full;
    assign load         = i_item.valid && i_item.ready;
    assign o_cmd        = r_cmd;

    always_comb begin
        n_cmd.op   = bfks_pkg::t_op'(i_item.op);
        n_cmd.walk = (n_cmd.op == bfks_pkg::OP_SEARCH) || (n_cmd.op == bfks_pkg::OP_LIST);
        n_cmd.code = i_item.code;
        n_cmd.tag  = i_item.name_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

`default_nettype wire

/* hdl/bfks_cmd_q.sv */
// short command queue between the front and back stages
`default_nettype none

module bfks_cmd_q (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  bfks_pkg::t_cmd      i_cmd,
    input  logic                i_pop,
    output bfks_pkg::t_cmd      o_cmd,
    output bfks_pkg::t_q_st     o_st
);

    localparam int FILL_W = $clog2(bfks_pkg::CMDQ_DEPTH + 1);

    bfks_pkg::t_cmd                   r_slot [bfks_pkg::CMDQ_DEPTH];
    logic [bfks_pkg::CMDQ_AW-1:0]     r_wr_ptr;
    logic [bfks_pkg::CMDQ_AW-1:0]     r_rd_ptr;
    logic [FILL_W-1:0]                r_fill;
    logic                             do_push;
    logic                             do_pop;

    assign o_st.full  = (r_fill == FILL_W'(bfks_pkg::CMDQ_DEPTH));
    assign o_st.empty = (r_fill == '0);
    assign do_push    = i_push && !o_st.full;
    assign do_pop     = i_pop && !o_st.empty;
    assign o_cmd      = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (int'(r_wr_ptr) == bfks_pkg::CMDQ_DEPTH - 1) ? '0
                                                                         : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (int'(r_rd_ptr) == bfks_pkg::CMDQ_DEPTH - 1) ? '0
                                                                         : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

/* hdl/bfks_back.sv */
// back stage: entry store, command sequencer and result register
`default_nettype none

module bfks_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bfks_pkg::t_cmd      i_cmd,
    input  bfks_pkg::t_q_st     i_q_st,
    output logic                o_pop,
    bfks_cfg_if.sink            i_cfg,
    bfks_result_if.source       o_result
);

    localparam int AW = bfks_pkg::ADDR_W;
    localparam int CW = bfks_pkg::CNT_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_CHK  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    logic signed [bfks_pkg::CODE_W-1:0] mem_code [bfks_pkg::DEPTH];
    logic [bfks_pkg::TAG_W-1:0]         mem_tag  [bfks_pkg::DEPTH];

    t_state                             r_state, n_state;
    bfks_pkg::t_cmd                     r_cmd, n_cmd;
    logic [CW-1:0]                      r_idx, n_idx;
    logic [AW-1:0]                      r_head, n_head;
    logic [CW-1:0]                      r_count, n_count;
    logic [bfks_pkg::CAP_W-1:0]         r_cap;
    logic [CW-1:0]                      r_found, n_found;
    logic signed [bfks_pkg::CODE_W-1:0] r_fcode, n_fcode;
    logic [bfks_pkg::TAG_W-1:0]         r_ftag, n_ftag;
    logic signed [bfks_pkg::CODE_W-1:0] r_rd_code;
    logic [bfks_pkg::TAG_W-1:0]         r_rd_tag;
    logic                               r_out_valid;
    bfks_pkg::t_result                  r_out;

    bfks_pkg::t_result                  res;
    logic                               load_out;
    logic                               out_free;
    logic                               wr_en;
    logic                               rd_en;
    logic [AW-1:0]                      wr_addr;
    logic [AW-1:0]                      rd_addr;
    logic [CW-1:0]                      cap;
    logic [CW-1:0]                      idx_nx;
    logic                               last_idx;

    assign out_free = !r_out_valid || o_result.ready;
    assign cap      = bfks_pkg::cap_of(r_cap);
    assign idx_nx   = r_idx + CW'(1);
    assign last_idx = (idx_nx == r_count);
    assign wr_addr  = bfks_pkg::wrap_add(r_head, r_count);
    assign rd_addr  = bfks_pkg::wrap_add(r_head, r_idx);
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_idx    = r_idx;
        n_head   = r_head;
        n_count  = r_count;
        n_found  = r_found;
        n_fcode  = r_fcode;
        n_ftag   = r_ftag;
        o_pop    = 1'b0;
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        load_out = 1'b0;
        res      = '0;
        res.status = bfks_pkg::ST_OK;
        case (r_state)
            S_IDLE: begin
                if (!i_q_st.empty && out_free) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_cmd;
                    n_idx   = '0;
                    n_found = '0;
                    if (i_cmd.op == bfks_pkg::OP_ENQ) begin
                        load_out = 1'b1;
                        res.last = 1'b1;
                        if (r_count >= cap) begin
                            res.status = bfks_pkg::ST_FULL;
                        end else begin
                            wr_en   = 1'b1;
                            n_count = r_count + CW'(1);
                        end
                    end else if (r_count == '0) begin
                        load_out   = 1'b1;
                        res.last   = 1'b1;
                        res.status = bfks_pkg::ST_EMPTY;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                rd_en   = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_cmd.walk) begin
                    if (r_cmd.op == bfks_pkg::OP_SEARCH) begin
                        if (r_rd_code == r_cmd.code) begin
                            n_found = idx_nx;
                            n_fcode = r_rd_code;
                            n_ftag  = r_rd_tag;
                        end
                        if (last_idx) begin
                            n_state = S_FIN;
                        end else begin
                            n_idx   = idx_nx;
                            n_state = S_RD;
                        end
                    end else if (out_free) begin
                        load_out       = 1'b1;
                        res.position   = bfks_pkg::POS_W'(idx_nx);
                        res.entry_code = r_rd_code;
                        res.entry_tag  = r_rd_tag;
                        res.last       = last_idx;
                        if (last_idx) begin
                            n_state = S_IDLE;
                        end else begin
                            n_idx   = idx_nx;
                            n_state = S_RD;
                        end
                    end
                end else if (out_free) begin
                    load_out       = 1'b1;
                    res.entry_code = r_rd_code;
                    res.entry_tag  = r_rd_tag;
                    res.last       = 1'b1;
                    n_head         = bfks_pkg::wrap_add(r_head, CW'(1));
                    n_count        = r_count - CW'(1);
                    n_state        = S_IDLE;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    load_out = 1'b1;
                    res.last = 1'b1;
                    if (r_found == '0) begin
                        res.status = bfks_pkg::ST_NOT_FOUND;
                    end else begin
                        res.position   = bfks_pkg::POS_W'(r_found);
                        res.entry_code = r_fcode;
                        res.entry_tag  = r_ftag;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_cap       <= bfks_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            if (i_cfg.valid) begin
                r_cap <= i_cfg.capacity_limit;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_idx   <= n_idx;
        r_found <= n_found;
        r_fcode <= n_fcode;
        r_ftag  <= n_ftag;
        if (load_out) begin
            r_out <= res;
        end
    end

    // entry store
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_code[wr_addr] <= i_cmd.code;
            mem_tag[wr_addr]  <= i_cmd.tag;
        end
        if (rd_en) begin
            r_rd_code <= mem_code[rd_addr];
            r_rd_tag  <= mem_tag[rd_addr];
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.status     = r_out.status;
    assign o_result.position   = r_out.position;
    assign o_result.entry_code = r_out.entry_code;
    assign o_result.entry_tag  = r_out.entry_tag;
    assign o_result.last       = r_out.last;

endmodule

`default_nettype wire

/* hdl/bounded_fifo_with_key_search.sv */
// top level of the bounded fifo with key search
//
// i_item carries one command word: op (enqueue, dequeue, search, list), code
// and name_tag. o_result returns result words: status, position, entry_code,
// entry_tag and last, which marks the final word of a command. enqueue,
// dequeue and search give one word, list gives one per held entry (one
// empty word when nothing is held). i_cfg writes the capacity limit,
// clamped to the store depth; it is always ready. the user is to write it
// only while idle; the block itself does not enforce this. commands pass a
// register stage and a two-word queue into the sequencer, so a new command
// is taken while an earlier one is still being worked. the sequencer reads
// the store one entry at a time through its single registered read port:
// search reads every held entry before its one word, and list gives a word
// per entry as it is read. reset empties the queue, clears head and count
// and sets the capacity to 5. a stalled result waits in the output
// register; the sequencer stops, the command queue fills and i_item.ready
// drops only once it is full.
`default_nettype none

module bounded_fifo_with_key_search (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bfks_item_if.sink       i_item,
    bfks_cfg_if.sink        i_cfg,
    bfks_result_if.source   o_result
);

    bfks_pkg::t_cmd   front_cmd;
    bfks_pkg::t_cmd   q_cmd;
    bfks_pkg::t_q_st  q_st;
    logic             push;
    logic             pop;

    bfks_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_q_st  (q_st),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    bfks_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (q_cmd),
        .o_st    (q_st)
    );

    bfks_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (q_cmd),
        .i_q_st   (q_st),
        .o_pop    (pop),
        .i_cfg    (i_cfg),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

/* hdl/bfks_checker.sv */
// port checker for the bounded fifo with key search, bound to the top level
`default_nettype none

module bfks_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic [bfks_pkg::STATUS_W-1:0]       i_status,
    input logic [bfks_pkg::POS_W-1:0]          i_position,
    input logic signed [bfks_pkg::CODE_W-1:0]  i_entry_code,
    input logic [bfks_pkg::TAG_W-1:0]          i_entry_tag,
    input logic                                i_last
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_position) && $stable(i_entry_code) && $stable(i_entry_tag)
            && $stable(i_last))
        else $error("stalled result changed");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != bfks_pkg::ST_OK |->
            i_position == '0 && i_entry_code == '0 && i_entry_tag == '0)
        else $error("failure result carries entry data");

    a_fail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != bfks_pkg::ST_OK |-> i_last)
        else $error("failure result not marked last");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> int'(i_position) <= bfks_pkg::DEPTH)
        else $error("position beyond store depth");

endmodule

bind bounded_fifo_with_key_search bfks_checker u_bfks_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_status     (o_result.status),
    .i_position   (o_result.position),
    .i_entry_code (o_result.entry_code),
    .i_entry_tag  (o_result.entry_tag),
    .i_last       (o_result.last)
);

`default_nettype wire
